/* design/tpam_pkg.sv */
`timescale 1ns / 1ps

package tpam_pkg;

    localparam int MAX_CRESTS_DEF    = 32;
    localparam int ANGLE_FRAC_BITS   = 8;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int TABLE_FRAC        = 20;

    localparam int COORD_W   = 17;
    localparam int CORNER_W  = 34;
    localparam int SIZE_W    = 12;
    localparam int SX_W      = 19;
    localparam int DX_W      = 18;
    localparam int AX_W      = 21;
    localparam int PROD_W    = AX_W + DX_W;
    localparam int PROJ_W    = 40;
    localparam int DIFF_W    = 41;
    localparam int CX_W      = 46;
    localparam int Z_W       = 30;
    localparam int ZD_W      = Z_W + 1;
    localparam int PHASE_W   = 15;
    localparam int COUNT_W   = 6;
    localparam int STATUS_W  = 3;
    localparam int PRESCALE_BIT = 40;
    localparam int IT_W      = 5;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int OUT_W     = 24;
    localparam int IN_W      = 72;

    localparam int RSH        = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam int RND_HALF   = 1 << (RSH - 1);
    localparam int PHASE_LIMIT = ((90 << ANGLE_FRAC_BITS) > 32767) ? 32767
                                 : (90 << ANGLE_FRAC_BITS);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_FEW   = 3'd1,
        ST_AXIS  = 3'd2,
        ST_NONE  = 3'd3,
        ST_PHASE = 3'd4,
        ST_OVF   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_TL = 3'd0,
        REG_TR = 3'd1,
        REG_BR = 3'd2,
        REG_BL = 3'd3,
        REG_WW = 3'd4,
        REG_WH = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CORNER_W-1:0] tl;
        logic [CORNER_W-1:0] tr;
        logic [CORNER_W-1:0] br;
        logic [CORNER_W-1:0] bl;
        logic [SIZE_W-1:0]   ww;
        logic [SIZE_W-1:0]   wh;
    } cfg_t;

    typedef struct packed {
        logic              side;
        logic [PROJ_W-1:0] along;
        logic [PROJ_W-1:0] radial;
    } pt_entry_t;

    typedef struct packed {
        logic              start;
        logic [DIFF_W-1:0] da;
        logic [DIFF_W-1:0] dr;
    } cordic_req_t;

    typedef struct packed {
        logic           done;
        logic [Z_W-1:0] angle;
    } cordic_rsp_t;

    typedef enum logic [1:0] {
        CD_IDLE,
        CD_NORM,
        CD_ITER
    } cordic_state_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD2, S_CHECK,
        S_PR_RD, S_PR_AX, S_PR_MUL, S_PR_WR,
        S_RK_LD, S_RK_LDW, S_RK_RD, S_RK_CMP, S_RK_WR,
        S_TR_ORD, S_TR_PT, S_TR_PTW, S_TR_DIFF, S_TR_TEST,
        S_TR_A1, S_TR_A2, S_TR_ROUND, S_INS_RD, S_INS_CMP, S_TR_NEXT,
        S_MED_RD, S_MED_CAP, S_OUT
    } top_state_t;

    // arctangent of 2^-i in degrees, TABLE_FRAC fraction bits
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [IT_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 30'sd47185920;
            5'd1:  v = 30'sd27855475;
            5'd2:  v = 30'sd14718068;
            5'd3:  v = 30'sd7471121;
            5'd4:  v = 30'sd3750058;
            5'd5:  v = 30'sd1876857;
            5'd6:  v = 30'sd938658;
            5'd7:  v = 30'sd469357;
            5'd8:  v = 30'sd234682;
            5'd9:  v = 30'sd117342;
            5'd10: v = 30'sd58671;
            5'd11: v = 30'sd29335;
            5'd12: v = 30'sd14668;
            5'd13: v = 30'sd7334;
            5'd14: v = 30'sd3667;
            5'd15: v = 30'sd1833;
            5'd16: v = 30'sd917;
            5'd17: v = 30'sd458;
            5'd18: v = 30'sd229;
            5'd19: v = 30'sd115;
            5'd20: v = 30'sd57;
            5'd21: v = 30'sd29;
            5'd22: v = 30'sd14;
            5'd23: v = 30'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/tpam_regs.sv */
`timescale 1ns / 1ps

module tpam_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpam_pkg::ADDR_W-1:0]  paddr,
    input  logic [tpam_pkg::DATA_W-1:0]  pwdata,
    output logic [tpam_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output tpam_pkg::cfg_t               cfg
);

    tpam_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[5:3])
                tpam_pkg::REG_TL: cfg_reg.tl <= pwdata[tpam_pkg::CORNER_W-1:0];
                tpam_pkg::REG_TR: cfg_reg.tr <= pwdata[tpam_pkg::CORNER_W-1:0];
                tpam_pkg::REG_BR: cfg_reg.br <= pwdata[tpam_pkg::CORNER_W-1:0];
                tpam_pkg::REG_BL: cfg_reg.bl <= pwdata[tpam_pkg::CORNER_W-1:0];
                tpam_pkg::REG_WW: cfg_reg.ww <= pwdata[tpam_pkg::SIZE_W-1:0];
                tpam_pkg::REG_WH: cfg_reg.wh <= pwdata[tpam_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            tpam_pkg::REG_TL: prdata = tpam_pkg::DATA_W'(cfg_reg.tl);
            tpam_pkg::REG_TR: prdata = tpam_pkg::DATA_W'(cfg_reg.tr);
            tpam_pkg::REG_BR: prdata = tpam_pkg::DATA_W'(cfg_reg.br);
            tpam_pkg::REG_BL: prdata = tpam_pkg::DATA_W'(cfg_reg.bl);
            tpam_pkg::REG_WW: prdata = tpam_pkg::DATA_W'(cfg_reg.ww);
            tpam_pkg::REG_WH: prdata = tpam_pkg::DATA_W'(cfg_reg.wh);
            default:          prdata = '0;
        endcase
    end

endmodule

/* design/tpam_cordic.sv */
`timescale 1ns / 1ps

module tpam_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tpam_pkg::cordic_req_t req,
    output tpam_pkg::cordic_rsp_t rsp
);

    localparam int CX_W = tpam_pkg::CX_W;
    localparam int Z_W  = tpam_pkg::Z_W;
    localparam int PB   = tpam_pkg::PRESCALE_BIT;

    tpam_pkg::cordic_state_t state_reg, state_next;
    logic signed [CX_W-1:0]       x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [Z_W-1:0]        z_reg, z_next;
    logic [tpam_pkg::IT_W-1:0]    it_reg, it_next;
    logic                         done_reg, done_next;

    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign rsp.done  = done_reg;
    assign rsp.angle = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpam_pkg::CD_IDLE;
            done_reg  <= 1'b0;
            it_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            it_reg    <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        it_next    = it_reg;
        done_next  = 1'b0;
        case (state_reg)
            tpam_pkg::CD_IDLE:
            begin
                if (req.start)
                begin
                    x_next     = $signed(CX_W'(req.da));
                    y_next     = $signed(CX_W'(req.dr));
                    z_next     = '0;
                    state_next = tpam_pkg::CD_NORM;
                end
            end
            tpam_pkg::CD_NORM:
            begin
                // scale up one bit per cycle until the larger operand reaches the top range
                if (!(|(x_reg[CX_W-1:PB] | y_reg[CX_W-1:PB])))
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
                else
                begin
                    it_next    = '0;
                    state_next = tpam_pkg::CD_ITER;
                end
            end
            tpam_pkg::CD_ITER:
            begin
                if (!y_reg[CX_W-1] && (|y_reg))
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + tpam_pkg::atan_entry(it_reg);
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - tpam_pkg::atan_entry(it_reg);
                end
                if (it_reg == tpam_pkg::IT_W'(tpam_pkg::CORDIC_ITERATIONS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = tpam_pkg::CD_IDLE;
                end
                else
                begin
                    it_next = it_reg + 1'b1;
                end
            end
            default: state_next = tpam_pkg::CD_IDLE;
        endcase
    end

endmodule

/* design/thread_phase_angle_median.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  crest pair in s_tdata, end of image on s_tlast
// m_*       out  m_tvalid/m_tready  status, phase, count in m_tdata, valid_res on m_tuser
// apb       in   psel/penable       quad corners and warped size, 8-byte register slots
//
// A crest pair is two writes into the point memory; a pair that finds the store full is dropped and flagged.
// The last pair adds a finish pass over n = 2*crests points: projection, rank counting
// through the single memory read port, then a triple walk that runs the angle unit twice
// and a sorted insertion for each qualifying triple, then a median read.
// Reset clears counters and flags only; memories hold garbage until written.
// A waiting result is held in the output register while new pairs load.

module thread_phase_angle_median #(
    parameter int MAX_CRESTS = tpam_pkg::MAX_CRESTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // top_x[16:0], top_y[33:17], bottom_x[50:34], bottom_y[67:51], zero pad
    input  logic [tpam_pkg::IN_W-1:0]     s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[2:0], phase_degrees[17:3], sample_count[23:18]
    output logic [tpam_pkg::OUT_W-1:0]    m_tdata,
    // valid_res[0]
    output logic                          m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpam_pkg::ADDR_W-1:0]   paddr,
    input  logic [tpam_pkg::DATA_W-1:0]   pwdata,
    output logic [tpam_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int NPTS = 2 * MAX_CRESTS;
    localparam int PW   = $clog2(NPTS);
    localparam int NW   = PW + 1;
    localparam int AAW  = PW + 1;
    localparam int CW   = $clog2(MAX_CRESTS + 1);
    localparam int COORD_W = tpam_pkg::COORD_W;
    localparam int PROJ_W  = tpam_pkg::PROJ_W;
    localparam int DIFF_W  = tpam_pkg::DIFF_W;
    localparam int Z_W     = tpam_pkg::Z_W;
    localparam int ZD_W    = tpam_pkg::ZD_W;
    localparam int PHASE_W = tpam_pkg::PHASE_W;
    localparam int AX_W    = tpam_pkg::AX_W;
    localparam int DX_W    = tpam_pkg::DX_W;
    localparam int SX_W    = tpam_pkg::SX_W;
    localparam int PROD_W  = tpam_pkg::PROD_W;

    tpam_pkg::cfg_t        cfg;
    tpam_pkg::cordic_req_t creq;
    tpam_pkg::cordic_rsp_t crsp;

    tpam_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpam_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    // point memory and order/phase memory
    tpam_pkg::pt_entry_t pt_mem [NPTS];
    tpam_pkg::pt_entry_t pt_rdata_reg, pt_wdata;
    logic                pt_we, pt_re;
    logic [PW-1:0]       pt_waddr, pt_raddr;

    logic [PHASE_W-1:0]  aux_mem [2*NPTS];
    logic [PHASE_W-1:0]  aux_rdata_reg, aux_wdata;
    logic                aux_we, aux_re;
    logic [AAW-1:0]      aux_waddr, aux_raddr;

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_waddr] <= pt_wdata;
        if (pt_re)
            pt_rdata_reg <= pt_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (aux_we)
            aux_mem[aux_waddr] <= aux_wdata;
        if (aux_re)
            aux_rdata_reg <= aux_mem[aux_raddr];
    end

    tpam_pkg::top_state_t state_reg, state_next;
    logic [CW-1:0]      crest_cnt_reg, crest_cnt_next;
    logic               ovf_reg, ovf_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [NW-1:0]      i_reg, i_next, j_reg, j_next, k_reg, k_next, cnt_reg, cnt_next;
    logic [PW-1:0]      rank_reg, rank_next;

    logic               last_reg, last_next;
    logic signed [COORD_W-1:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [SX_W-1:0]    sx_reg, sx_next, sy_reg, sy_next;
    logic signed [DX_W-1:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic signed [AX_W-1:0]    ax_reg, ax_next, ay_reg, ay_next;
    logic               side_reg, side_next;
    logic signed [PROD_W-1:0]  paa_reg, paa_next, pay_reg, pay_next;
    logic signed [PROD_W-1:0]  pra_reg, pra_next, prd_reg, prd_next;
    logic signed [PROJ_W-1:0]  ref_along_reg, ref_along_next;
    tpam_pkg::pt_entry_t w0_reg, w0_next, w1_reg, w1_next, w2_reg, w2_next;
    logic [DIFF_W-1:0]  da1_reg, da1_next, dr1_reg, dr1_next;
    logic [DIFF_W-1:0]  da2_reg, da2_next, dr2_reg, dr2_next;
    logic               alt_reg, alt_next;
    logic signed [Z_W-1:0] z1_reg, z1_next, z2_reg, z2_next;
    logic [PHASE_W-1:0] d_reg, d_next;
    logic [tpam_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic               res_valid_reg, res_valid_next;
    logic [PHASE_W-1:0] res_phase_reg, res_phase_next;
    logic [tpam_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    logic [NW-1:0]      n_pts;
    logic [PW-1:0]      ld_addr;
    logic [AAW-1:0]     phase_base;
    logic signed [COORD_W-1:0] pt_x, pt_y;
    logic signed [COORD_W-1:0] in_tx, in_ty;
    logic               axis_bad;
    logic signed [ZD_W-1:0] zdiff;
    logic [ZD_W-1:0]    zabs, zrnd, zsh;
    logic [PHASE_W-1:0] d_sat;
    logic [tpam_pkg::COUNT_W-1:0] out_count;

    function automatic logic [DIFF_W-1:0] absdiff(input logic signed [PROJ_W-1:0] a,
                                                  input logic signed [PROJ_W-1:0] b);
        logic signed [DIFF_W-1:0] t;
        t = DIFF_W'(a) - DIFF_W'(b);
        return t[DIFF_W-1] ? DIFF_W'(-t) : DIFF_W'(t);
    endfunction

    function automatic logic signed [SX_W-1:0] cx(input logic [tpam_pkg::CORNER_W-1:0] c);
        return SX_W'($signed(c[COORD_W-1:0]));
    endfunction

    function automatic logic signed [SX_W-1:0] cy(input logic [tpam_pkg::CORNER_W-1:0] c);
        return SX_W'($signed(c[2*COORD_W-1:COORD_W]));
    endfunction

    assign n_pts      = NW'({crest_cnt_reg, 1'b0});
    assign ld_addr    = PW'({crest_cnt_reg, 1'b0});
    assign phase_base = AAW'(NPTS);
    assign pt_x       = $signed(pt_rdata_reg.along[COORD_W-1:0]);
    assign pt_y       = $signed(pt_rdata_reg.radial[COORD_W-1:0]);
    assign in_tx      = $signed(s_tdata[COORD_W-1:0]);
    assign in_ty      = $signed(s_tdata[2*COORD_W-1:COORD_W]);
    assign axis_bad   = (cfg.ww < tpam_pkg::SIZE_W'(2)) || (cfg.wh < tpam_pkg::SIZE_W'(2))
                        || (cfg.tl == cfg.tr);

    // round the angle difference half up and clamp at ninety degrees
    assign zdiff = ZD_W'(z1_reg) - ZD_W'(z2_reg);
    assign zabs  = zdiff[ZD_W-1] ? ZD_W'(-zdiff) : ZD_W'(zdiff);
    assign zrnd  = zabs + ZD_W'(tpam_pkg::RND_HALF);
    assign zsh   = zrnd >> tpam_pkg::RSH;
    assign d_sat = (zsh > ZD_W'(tpam_pkg::PHASE_LIMIT)) ? PHASE_W'(tpam_pkg::PHASE_LIMIT)
                                                       : PHASE_W'(zsh);
    assign out_count = res_valid_reg ? tpam_pkg::COUNT_W'(cnt_reg) : '0;

    assign s_tready = (state_reg == tpam_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpam_pkg::S_IDLE;
            crest_cnt_reg <= '0;
            ovf_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            rank_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            crest_cnt_reg <= crest_cnt_next;
            ovf_reg       <= ovf_next;
            m_tvalid_reg  <= m_tvalid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        bx_reg         <= bx_next;
        by_reg         <= by_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        side_reg       <= side_next;
        paa_reg        <= paa_next;
        pay_reg        <= pay_next;
        pra_reg        <= pra_next;
        prd_reg        <= prd_next;
        ref_along_reg  <= ref_along_next;
        w0_reg         <= w0_next;
        w1_reg         <= w1_next;
        w2_reg         <= w2_next;
        da1_reg        <= da1_next;
        dr1_reg        <= dr1_next;
        da2_reg        <= da2_next;
        dr2_reg        <= dr2_next;
        alt_reg        <= alt_next;
        z1_reg         <= z1_next;
        z2_reg         <= z2_next;
        d_reg          <= d_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_phase_reg  <= res_phase_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        crest_cnt_next  = crest_cnt_reg;
        ovf_next        = ovf_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        rank_next       = rank_reg;
        last_next       = last_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        side_next       = side_reg;
        paa_next        = paa_reg;
        pay_next        = pay_reg;
        pra_next        = pra_reg;
        prd_next        = prd_reg;
        ref_along_next  = ref_along_reg;
        w0_next         = w0_reg;
        w1_next         = w1_reg;
        w2_next         = w2_reg;
        da1_next        = da1_reg;
        dr1_next        = dr1_reg;
        da2_next        = da2_reg;
        dr2_next        = dr2_reg;
        alt_next        = alt_reg;
        z1_next         = z1_reg;
        z2_next         = z2_reg;
        d_next          = d_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_phase_next  = res_phase_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        pt_we     = 1'b0;
        pt_re     = 1'b0;
        pt_waddr  = i_reg[PW-1:0];
        pt_raddr  = i_reg[PW-1:0];
        pt_wdata  = '0;
        aux_we    = 1'b0;
        aux_re    = 1'b0;
        aux_waddr = '0;
        aux_raddr = '0;
        aux_wdata = '0;
        creq.start = 1'b0;
        creq.da    = da1_reg;
        creq.dr    = dr1_reg;

        case (state_reg)
            tpam_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    last_next = s_tlast;
                    if (crest_cnt_reg < CW'(MAX_CRESTS))
                    begin
                        pt_we           = 1'b1;
                        pt_waddr        = ld_addr;
                        pt_wdata.side   = 1'b0;
                        pt_wdata.along  = PROJ_W'(in_tx);
                        pt_wdata.radial = PROJ_W'(in_ty);
                        bx_next         = $signed(s_tdata[3*COORD_W-1:2*COORD_W]);
                        by_next         = $signed(s_tdata[4*COORD_W-1:3*COORD_W]);
                        state_next      = tpam_pkg::S_LOAD2;
                    end
                    else
                    begin
                        // store full: drop the pair and flag it
                        ovf_next = 1'b1;
                        if (s_tlast)
                            state_next = tpam_pkg::S_CHECK;
                    end
                end
            end
            tpam_pkg::S_LOAD2:
            begin
                pt_we           = 1'b1;
                pt_waddr        = {ld_addr[PW-1:1], 1'b1};
                pt_wdata.side   = 1'b1;
                pt_wdata.along  = PROJ_W'(bx_reg);
                pt_wdata.radial = PROJ_W'(by_reg);
                crest_cnt_next  = crest_cnt_reg + 1'b1;
                state_next      = last_reg ? tpam_pkg::S_CHECK : tpam_pkg::S_IDLE;
            end
            tpam_pkg::S_CHECK:
            begin
                cnt_next       = '0;
                res_valid_next = 1'b0;
                res_phase_next = '0;
                if (crest_cnt_reg < CW'(2))
                begin
                    res_status_next = tpam_pkg::ST_FEW;
                    state_next      = tpam_pkg::S_OUT;
                end
                else if (axis_bad)
                begin
                    res_status_next = tpam_pkg::ST_AXIS;
                    state_next      = tpam_pkg::S_OUT;
                end
                else
                begin
                    sx_next    = cx(cfg.tl) + cx(cfg.tr) + cx(cfg.br) + cx(cfg.bl);
                    sy_next    = cy(cfg.tl) + cy(cfg.tr) + cy(cfg.br) + cy(cfg.bl);
                    dx_next    = DX_W'(cx(cfg.tr) - cx(cfg.tl));
                    dy_next    = DX_W'(cy(cfg.tr) - cy(cfg.tl));
                    i_next     = '0;
                    state_next = tpam_pkg::S_PR_RD;
                end
            end
            tpam_pkg::S_PR_RD:
            begin
                pt_re      = 1'b1;
                state_next = tpam_pkg::S_PR_AX;
            end
            tpam_pkg::S_PR_AX:
            begin
                ax_next    = (AX_W'(pt_x) <<< 2) - AX_W'(sx_reg);
                ay_next    = (AX_W'(pt_y) <<< 2) - AX_W'(sy_reg);
                side_next  = pt_rdata_reg.side;
                state_next = tpam_pkg::S_PR_MUL;
            end
            tpam_pkg::S_PR_MUL:
            begin
                paa_next   = ax_reg * dx_reg;
                pay_next   = ay_reg * dy_reg;
                pra_next   = ay_reg * dx_reg;
                prd_next   = ax_reg * dy_reg;
                state_next = tpam_pkg::S_PR_WR;
            end
            tpam_pkg::S_PR_WR:
            begin
                pt_we           = 1'b1;
                pt_wdata.side   = side_reg;
                pt_wdata.along  = PROJ_W'(paa_reg) + PROJ_W'(pay_reg);
                pt_wdata.radial = PROJ_W'(pra_reg) - PROJ_W'(prd_reg);
                if (i_reg + 1'b1 == n_pts)
                begin
                    i_next     = '0;
                    state_next = tpam_pkg::S_RK_LD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = tpam_pkg::S_PR_RD;
                end
            end
            tpam_pkg::S_RK_LD:
            begin
                pt_re      = 1'b1;
                state_next = tpam_pkg::S_RK_LDW;
            end
            tpam_pkg::S_RK_LDW:
            begin
                ref_along_next = $signed(pt_rdata_reg.along);
                j_next         = '0;
                rank_next      = '0;
                state_next     = tpam_pkg::S_RK_RD;
            end
            tpam_pkg::S_RK_RD:
            begin
                pt_re      = 1'b1;
                pt_raddr   = j_reg[PW-1:0];
                state_next = tpam_pkg::S_RK_CMP;
            end
            tpam_pkg::S_RK_CMP:
            begin
                // stable rank: count smaller keys, and equal keys loaded earlier
                if (($signed(pt_rdata_reg.along) < ref_along_reg) ||
                    (($signed(pt_rdata_reg.along) == ref_along_reg) && (j_reg < i_reg)))
                    rank_next = rank_reg + 1'b1;
                j_next = j_reg + 1'b1;
                if (j_reg + 1'b1 == n_pts)
                    state_next = tpam_pkg::S_RK_WR;
                else
                    state_next = tpam_pkg::S_RK_RD;
            end
            tpam_pkg::S_RK_WR:
            begin
                aux_we    = 1'b1;
                aux_waddr = AAW'(rank_reg);
                aux_wdata = PHASE_W'(i_reg);
                if (i_reg + 1'b1 == n_pts)
                begin
                    k_next     = '0;
                    state_next = tpam_pkg::S_TR_ORD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = tpam_pkg::S_RK_LD;
                end
            end
            tpam_pkg::S_TR_ORD:
            begin
                aux_re     = 1'b1;
                aux_raddr  = AAW'(k_reg);
                state_next = tpam_pkg::S_TR_PT;
            end
            tpam_pkg::S_TR_PT:
            begin
                pt_re      = 1'b1;
                pt_raddr   = aux_rdata_reg[PW-1:0];
                state_next = tpam_pkg::S_TR_PTW;
            end
            tpam_pkg::S_TR_PTW:
            begin
                w0_next = w1_reg;
                w1_next = w2_reg;
                w2_next = pt_rdata_reg;
                k_next  = k_reg + 1'b1;
                if (k_reg >= NW'(2))
                    state_next = tpam_pkg::S_TR_DIFF;
                else
                    state_next = tpam_pkg::S_TR_ORD;
            end
            tpam_pkg::S_TR_DIFF:
            begin
                da1_next   = absdiff($signed(w1_reg.along), $signed(w0_reg.along));
                dr1_next   = absdiff($signed(w1_reg.radial), $signed(w0_reg.radial));
                da2_next   = absdiff($signed(w2_reg.along), $signed(w1_reg.along));
                dr2_next   = absdiff($signed(w2_reg.radial), $signed(w1_reg.radial));
                alt_next   = (w0_reg.side != w1_reg.side) && (w1_reg.side != w2_reg.side);
                state_next = tpam_pkg::S_TR_TEST;
            end
            tpam_pkg::S_TR_TEST:
            begin
                if (alt_reg && (|da1_reg) && (|dr1_reg) && (|da2_reg) && (|dr2_reg))
                begin
                    creq.start = 1'b1;
                    state_next = tpam_pkg::S_TR_A1;
                end
                else
                begin
                    state_next = tpam_pkg::S_TR_NEXT;
                end
            end
            tpam_pkg::S_TR_A1:
            begin
                creq.da = da2_reg;
                creq.dr = dr2_reg;
                if (crsp.done)
                begin
                    z1_next    = $signed(crsp.angle);
                    creq.start = 1'b1;
                    state_next = tpam_pkg::S_TR_A2;
                end
            end
            tpam_pkg::S_TR_A2:
            begin
                if (crsp.done)
                begin
                    z2_next    = $signed(crsp.angle);
                    state_next = tpam_pkg::S_TR_ROUND;
                end
            end
            tpam_pkg::S_TR_ROUND:
            begin
                d_next     = d_sat;
                j_next     = cnt_reg;
                state_next = tpam_pkg::S_INS_RD;
            end
            tpam_pkg::S_INS_RD:
            begin
                if (j_reg == '0)
                begin
                    aux_we     = 1'b1;
                    aux_waddr  = phase_base;
                    aux_wdata  = d_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = tpam_pkg::S_TR_NEXT;
                end
                else
                begin
                    aux_re     = 1'b1;
                    aux_raddr  = phase_base + AAW'(j_reg) - 1'b1;
                    state_next = tpam_pkg::S_INS_CMP;
                end
            end
            tpam_pkg::S_INS_CMP:
            begin
                aux_we    = 1'b1;
                aux_waddr = phase_base + AAW'(j_reg);
                if (aux_rdata_reg > d_reg)
                begin
                    // shift the larger phase up one slot
                    aux_wdata  = aux_rdata_reg;
                    j_next     = j_reg - 1'b1;
                    state_next = tpam_pkg::S_INS_RD;
                end
                else
                begin
                    aux_wdata  = d_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = tpam_pkg::S_TR_NEXT;
                end
            end
            tpam_pkg::S_TR_NEXT:
            begin
                if (k_reg == n_pts)
                    state_next = tpam_pkg::S_MED_RD;
                else
                    state_next = tpam_pkg::S_TR_ORD;
            end
            tpam_pkg::S_MED_RD:
            begin
                if (cnt_reg == '0)
                begin
                    res_status_next = tpam_pkg::ST_NONE;
                    res_valid_next  = 1'b0;
                    res_phase_next  = '0;
                    state_next      = tpam_pkg::S_OUT;
                end
                else
                begin
                    aux_re     = 1'b1;
                    aux_raddr  = phase_base + AAW'(cnt_reg >> 1);
                    state_next = tpam_pkg::S_MED_CAP;
                end
            end
            tpam_pkg::S_MED_CAP:
            begin
                res_status_next = ovf_reg ? tpam_pkg::ST_OVF : tpam_pkg::ST_OK;
                res_valid_next  = 1'b1;
                res_phase_next  = aux_rdata_reg;
                state_next      = tpam_pkg::S_OUT;
            end
            tpam_pkg::S_OUT:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = {out_count, res_phase_reg, res_status_reg};
                    m_tuser_next   = res_valid_reg;
                    crest_cnt_next = '0;
                    ovf_next       = 1'b0;
                    state_next     = tpam_pkg::S_IDLE;
                end
            end
            default: state_next = tpam_pkg::S_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        crest_cnt_reg <= CW'(MAX_CRESTS))
        else $error("crest count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[17:3] <= PHASE_W'(tpam_pkg::PHASE_LIMIT)))
        else $error("phase above limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ((m_tdata[2:0] == tpam_pkg::ST_OK) ||
                                  (m_tdata[2:0] == tpam_pkg::ST_OVF))))
        else $error("valid_res disagrees with status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpam_pkg::S_TR_NEXT) |-> (cnt_reg <= k_reg))
        else $error("more phases than walked points");

endmodule
